// File: hdl/i2cm_pkg.sv
package i2cm_pkg;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_START = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_WRITE = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    OP_IDLE  = 5'b00001,
    OP_START = 5'b00010,
    OP_STOP  = 5'b00100,
    OP_WRITE = 5'b01000,
    OP_READ  = 5'b10000
  } op_t;

  typedef enum logic [1:0] {
    PH_SCL_HIGH = 2'd0,
    PH_SCL_LOW  = 2'd1,
    PH_SHIFT    = 2'd2
  } wr_phase_t;

  localparam logic [4:0] WR_LAST_SHIFT = 5'd23;
  localparam logic [4:0] WR_BITS_END   = 5'd24;
  localparam logic [4:0] WR_LAST_STEP  = 5'd25;
  localparam logic [4:0] RD_BITS_END   = 5'd15;
  localparam logic [4:0] RD_BITS_STOP  = 5'd16;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       send_ack;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_line;
    logic       sda_line;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       nack;
    logic       rejected;
  } res_t;

endpackage

// File: hdl/i2cm_if.sv
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, kind, data, send_ack, sda_in, input ready);
  modport sink (input valid, kind, data, send_ack, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_line;
  logic       sda_line;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_data;
  logic       nack;
  logic       rejected;

  modport source (output valid, scl_line, sda_line, busy_res, done_res, rx_data, nack,
                  rejected, input ready);
  modport sink (input valid, scl_line, sda_line, busy_res, done_res, rx_data, nack,
                rejected, output ready);
endinterface

// File: hdl/i2cm_in_reg.sv
module i2cm_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  i2cm_in_if.sink             in_ch,
  output logic                req_valid,
  output i2cm_pkg::req_t      req,
  input  logic                req_take
);

  logic           valid_r;
  i2cm_pkg::req_t req_r;

  assign in_ch.ready = !valid_r || req_take;
  assign req_valid   = valid_r;
  assign req         = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_r <= '{kind: in_ch.kind, data: in_ch.data, send_ack: in_ch.send_ack,
                 sda_in: in_ch.sda_in};
    end
  end

endmodule

// File: hdl/i2cm_engine.sv
module i2cm_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  i2cm_pkg::req_t      req,
  output logic                req_take,
  i2cm_out_if.source          out_ch
);

  i2cm_pkg::op_t       op_r, op_nxt;
  logic [4:0]          step_r, step_nxt;
  i2cm_pkg::wr_phase_t phase_r, phase_nxt;
  logic [7:0]          shift_r, shift_nxt;
  logic                ack_r, ack_nxt;
  logic                scl_r, scl_nxt;
  logic                sda_r, sda_nxt;
  logic                out_valid_r;
  i2cm_pkg::res_t      res_r, res_nxt;
  logic                done;
  logic                rej;
  logic [7:0]          rx;
  logic                nk;

  assign req_take = req_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    op_nxt    = op_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    ack_nxt   = ack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    done      = 1'b0;
    rej       = 1'b0;
    rx        = 8'd0;
    nk        = 1'b0;
    unique case (req.kind)
      i2cm_pkg::KIND_START, i2cm_pkg::KIND_STOP, i2cm_pkg::KIND_WRITE,
      i2cm_pkg::KIND_READ: begin
        if (op_r != i2cm_pkg::OP_IDLE) begin
          rej = 1'b1;
        end else begin
          step_nxt  = 5'd0;
          phase_nxt = i2cm_pkg::PH_SCL_HIGH;
          priority if (req.kind == i2cm_pkg::KIND_START) begin
            op_nxt  = i2cm_pkg::OP_START;
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end else if (req.kind == i2cm_pkg::KIND_STOP) begin
            op_nxt  = i2cm_pkg::OP_STOP;
            sda_nxt = 1'b0;
          end else if (req.kind == i2cm_pkg::KIND_WRITE) begin
            op_nxt    = i2cm_pkg::OP_WRITE;
            shift_nxt = req.data;
            sda_nxt   = req.data[7];
          end else begin
            op_nxt    = i2cm_pkg::OP_READ;
            shift_nxt = 8'd0;
            ack_nxt   = req.send_ack;
            sda_nxt   = 1'b1;
            scl_nxt   = 1'b1;
          end
        end
      end
      i2cm_pkg::KIND_TICK: begin
        step_nxt = step_r + 5'd1;
        unique case (op_r)
          i2cm_pkg::OP_START: begin
            if (step_r == 5'd0) begin
              sda_nxt = 1'b0;
            end else begin
              scl_nxt = 1'b0;
              done    = 1'b1;
            end
          end
          i2cm_pkg::OP_STOP: begin
            if (step_r == 5'd0) begin
              scl_nxt = 1'b1;
            end else begin
              sda_nxt = 1'b1;
              done    = 1'b1;
            end
          end
          i2cm_pkg::OP_WRITE: begin
            priority if (step_r < i2cm_pkg::WR_BITS_END) begin
              unique case (phase_r)
                i2cm_pkg::PH_SCL_HIGH: begin
                  scl_nxt   = 1'b1;
                  phase_nxt = i2cm_pkg::PH_SCL_LOW;
                end
                i2cm_pkg::PH_SCL_LOW: begin
                  scl_nxt   = 1'b0;
                  phase_nxt = i2cm_pkg::PH_SHIFT;
                end
                default: begin
                  shift_nxt = {shift_r[6:0], 1'b0};
                  sda_nxt   = (step_r < i2cm_pkg::WR_LAST_SHIFT) ? shift_r[6] : 1'b1;
                  phase_nxt = i2cm_pkg::PH_SCL_HIGH;
                end
              endcase
            end else if (step_r == i2cm_pkg::WR_BITS_END) begin
              scl_nxt = 1'b1;
            end else begin
              nk      = req.sda_in;
              scl_nxt = 1'b0;
              done    = 1'b1;
            end
          end
          i2cm_pkg::OP_READ: begin
            priority if (step_r < i2cm_pkg::RD_BITS_STOP && !step_r[0]) begin
              shift_nxt = {shift_r[6:0], req.sda_in};
              scl_nxt   = 1'b0;
            end else if (step_r < i2cm_pkg::RD_BITS_END) begin
              scl_nxt = 1'b1;
            end else if (step_r == i2cm_pkg::RD_BITS_END) begin
              sda_nxt = !ack_r;
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
              rx      = shift_r;
              done    = 1'b1;
            end
          end
          default: begin
            step_nxt = step_r;
          end
        endcase
        if (done) begin
          op_nxt    = i2cm_pkg::OP_IDLE;
          step_nxt  = 5'd0;
          phase_nxt = i2cm_pkg::PH_SCL_HIGH;
        end
      end
      default: ;
    endcase
    res_nxt = '{scl_line: scl_nxt, sda_line: sda_nxt,
                busy_res: (op_nxt != i2cm_pkg::OP_IDLE), done_res: done,
                rx_data: rx, nack: nk, rejected: rej};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= i2cm_pkg::OP_IDLE;
      step_r      <= 5'd0;
      phase_r     <= i2cm_pkg::PH_SCL_HIGH;
      shift_r     <= 8'd0;
      ack_r       <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (req_take) begin
        op_r    <= op_nxt;
        step_r  <= step_nxt;
        phase_r <= phase_nxt;
        shift_r <= shift_nxt;
        ack_r   <= ack_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
      end
      if (req_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.scl_line = res_r.scl_line;
  assign out_ch.sda_line = res_r.sda_line;
  assign out_ch.busy_res = res_r.busy_res;
  assign out_ch.done_res = res_r.done_res;
  assign out_ch.rx_data  = res_r.rx_data;
  assign out_ch.nack     = res_r.nack;
  assign out_ch.rejected = res_r.rejected;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> !res_r.busy_res && op_r == i2cm_pkg::OP_IDLE)
    else $error("completed command left the master busy");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    op_r == i2cm_pkg::OP_IDLE |-> step_r == 5'd0 && phase_r == i2cm_pkg::PH_SCL_HIGH)
    else $error("idle with a live step count");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= i2cm_pkg::WR_LAST_STEP)
    else $error("step count past the end of a write");

  a_report_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.rx_data != 8'd0 || res_r.nack) |-> res_r.done_res)
    else $error("read data or nack reported without completion");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    req_take && rej |=> $stable(op_r) && $stable(step_r) && $stable(shift_r))
    else $error("rejected command changed the sequence");
`endif

endmodule

// File: hdl/i2c_bit_level_master.sv
// Bit-level I2C master. Each request is either a tick (one 5 us half period) or a
// command: start, stop, write byte or read byte. Commands are taken only while
// idle and are otherwise returned with rejected set; every request yields exactly
// one result carrying the SCL and SDA levels after it. Start and stop run 2 ticks,
// a write 26 ticks (SDA sampled on the last, high means nack), a read 17 ticks.
// Throughput is one request per clock unless the output stalls; a request passes an
// input register and the line sequencer, whose state and result register are
// updated in the same cycle, and its result is shown from that result register.
module i2c_bit_level_master (
  input  logic        clk,
  input  logic        rst_n,
  i2cm_in_if.sink     in_ch,
  i2cm_out_if.source  out_ch
);

  logic           req_valid;
  logic           req_take;
  i2cm_pkg::req_t req;

  i2cm_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take)
  );

  i2cm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .out_ch    (out_ch)
  );

endmodule
